[hdl/tkd_pkg.sv]
// Shared types and constants for the terminal key event decoder queue.
package tkd_pkg;

    // Parser modes
    typedef enum logic [2:0] {
        MODE_IDLE = 3'd0,
        MODE_ESC  = 3'd1,
        MODE_CSI  = 3'd2,
        MODE_BTN  = 3'd3,
        MODE_COL  = 3'd4,
        MODE_ROW  = 3'd5
    } mode_t;

    // Event kinds
    localparam logic [2:0] KIND_UNDEF  = 3'd0;
    localparam logic [2:0] KIND_ARROW  = 3'd1;
    localparam logic [2:0] KIND_FOCUS  = 3'd2;
    localparam logic [2:0] KIND_CLICK  = 3'd3;
    localparam logic [2:0] KIND_IGNORE = 3'd4;
    localparam logic [2:0] KIND_LETTER = 3'd5;

    // Command codes on the input tuser
    localparam logic CMD_BYTE    = 1'b0;
    localparam logic CMD_DEQUEUE = 1'b1;

    // Byte values the parser looks for
    localparam logic [7:0] BYTE_LF      = 8'd10;
    localparam logic [7:0] BYTE_CR      = 8'd13;
    localparam logic [7:0] BYTE_ESC     = 8'd27;
    localparam logic [7:0] BYTE_SPACE   = 8'h20;
    localparam logic [7:0] BYTE_LBRACK  = 8'h5B;
    localparam logic [7:0] BYTE_UPPER_A = 8'h41;
    localparam logic [7:0] BYTE_UPPER_D = 8'h44;
    localparam logic [7:0] BYTE_UPPER_I = 8'h49;
    localparam logic [7:0] BYTE_UPPER_M = 8'h4D;
    localparam logic [7:0] BYTE_UPPER_O = 8'h4F;
    localparam logic [7:0] BYTE_UPPER_Z = 8'h5A;
    localparam logic [7:0] BYTE_LOWER_A = 8'h61;
    localparam logic [7:0] BYTE_LOWER_Z = 8'h7A;

    // Mouse coordinate offset of X10 reports
    localparam logic [8:0] MOUSE_OFFSET = 9'd33;

    // Depth of the op queue between front and back
    localparam int unsigned OPQ_DEPTH = 4;
    localparam int unsigned OPQ_IDX_W = 2;
    localparam int unsigned OPQ_CNT_W = 3;

    // One operation handed from the parser to the event ring
    typedef struct packed {
        logic             is_read;   // 1: dequeue, 0: write event
        logic [2:0]       kind;
        logic [7:0]       code;
        logic signed [8:0] col;      // mouse position snapshot for dequeue
        logic signed [8:0] row;
    } op_t;

endpackage

[hdl/tkd_front.sv]
// Byte parser: classifies terminal bytes and dequeue requests into queue ops.
module tkd_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             in_cmd,
    input  logic [7:0]       in_byte,
    input  logic             cfg_we,
    input  logic             cfg_wdata,
    input  logic             opq_full,
    output logic             op_push,
    output tkd_pkg::op_t     op
);
    import tkd_pkg::*;

    mode_t             mode_reg, mode_next;
    logic              rec_en_reg;
    logic [7:0]        button_reg;
    logic signed [8:0] col_reg;
    logic signed [8:0] row_reg;
    logic              accept;
    logic              byte_take;
    logic              ev_valid;
    logic [2:0]        ev_kind;
    logic [7:0]        ev_code;
    logic signed [8:0] pos;

    assign in_ready  = !opq_full;
    assign accept    = in_valid && in_ready;
    assign byte_take = accept && (in_cmd == CMD_BYTE);
    assign pos       = $signed({1'b0, in_byte} - MOUSE_OFFSET);

    // Next parser mode
    always_comb
    begin
        mode_next = mode_reg;
        unique case (mode_reg)
            MODE_IDLE: mode_next = (in_byte == BYTE_ESC) ? MODE_ESC : MODE_IDLE;
            MODE_ESC:  mode_next = (in_byte == BYTE_LBRACK) ? MODE_CSI : MODE_IDLE;
            MODE_CSI:  mode_next = (in_byte == BYTE_UPPER_M) ? MODE_BTN : MODE_IDLE;
            MODE_BTN:  mode_next = MODE_COL;
            MODE_COL:  mode_next = MODE_ROW;
            MODE_ROW:  mode_next = MODE_IDLE;
            default:   mode_next = MODE_IDLE;
        endcase
    end

    // Event recognized by the current byte
    always_comb
    begin
        ev_valid = 1'b0;
        ev_kind  = KIND_UNDEF;
        ev_code  = in_byte;
        unique case (mode_reg)
            MODE_IDLE:
            begin
                if ((in_byte >= BYTE_LOWER_A && in_byte <= BYTE_LOWER_Z) ||
                    (in_byte >= BYTE_UPPER_A && in_byte <= BYTE_UPPER_Z))
                begin
                    ev_valid = 1'b1;
                    ev_kind  = KIND_LETTER;
                end
                else if (in_byte == BYTE_LF || in_byte == BYTE_CR)
                begin
                    ev_valid = 1'b1;
                    ev_kind  = KIND_IGNORE;
                end
            end
            MODE_CSI:
            begin
                if (in_byte >= BYTE_UPPER_A && in_byte <= BYTE_UPPER_D)
                begin
                    ev_valid = 1'b1;
                    ev_kind  = KIND_ARROW;
                end
                else if (in_byte == BYTE_UPPER_I || in_byte == BYTE_UPPER_O)
                begin
                    ev_valid = 1'b1;
                    ev_kind  = KIND_FOCUS;
                end
            end
            MODE_ROW:
            begin
                ev_valid = 1'b1;
                ev_kind  = (button_reg == BYTE_SPACE) ? KIND_CLICK : KIND_IGNORE;
                ev_code  = button_reg;
            end
            default:
            begin
                ev_valid = 1'b0;
            end
        endcase
    end

    // Build the op for the queue
    always_comb
    begin
        op.is_read = (in_cmd == CMD_DEQUEUE);
        op.kind    = ev_kind;
        op.code    = ev_code;
        op.col     = col_reg;
        op.row     = row_reg;
        op_push    = accept && ((in_cmd == CMD_DEQUEUE) || (ev_valid && rec_en_reg));
    end

    // Control state: mode and recording enable
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            rec_en_reg <= 1'b1;
        end
        else
        begin
            if (byte_take)
            begin
                mode_reg <= mode_next;
            end
            if (cfg_we)
            begin
                rec_en_reg <= cfg_wdata;
            end
        end
    end

    // Mouse report fields
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            button_reg <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else if (byte_take)
        begin
            if (mode_reg == MODE_BTN)
            begin
                button_reg <= in_byte;
            end
            if (mode_reg == MODE_COL)
            begin
                col_reg <= pos;
            end
            if (mode_reg == MODE_ROW)
            begin
                row_reg <= pos;
            end
        end
    end

endmodule

[hdl/tkd_opq.sv]
// Short op queue between the parser and the event ring.
module tkd_opq (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  tkd_pkg::op_t  push_op,
    output logic          full,
    input  logic          pop,
    output logic          empty,
    output tkd_pkg::op_t  head_op
);
    import tkd_pkg::*;

    op_t                  slot_reg [OPQ_DEPTH];
    logic [OPQ_IDX_W-1:0] wr_ptr_reg;
    logic [OPQ_IDX_W-1:0] rd_ptr_reg;
    logic [OPQ_CNT_W-1:0] count_reg;
    logic                 do_push;
    logic                 do_pop;

    assign full    = (count_reg == OPQ_CNT_W'(OPQ_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head_op = slot_reg[rd_ptr_reg];

    // Store pushed ops
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[hdl/tkd_back.sv]
// Event ring: stores events, serves dequeues and holds the result word.
module tkd_back #(
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             opq_empty,
    input  tkd_pkg::op_t     head_op,
    output logic             opq_pop,
    output logic             res_valid,
    input  logic             res_ready,
    output logic             res_available,
    output logic [2:0]       res_kind,
    output logic [7:0]       res_code,
    output logic signed [8:0] res_col,
    output logic signed [8:0] res_row
);
    import tkd_pkg::*;

    localparam int unsigned IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

    logic [10:0]       ring_mem [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] consumed_reg;
    logic [IDX_W-1:0]  wr_idx_reg;
    logic [IDX_W-1:0]  rd_idx_reg;
    logic              out_valid_reg;
    logic              avail_reg;
    logic [10:0]       data_reg;
    logic signed [8:0] col_reg;
    logic signed [8:0] row_reg;
    logic              do_write;
    logic              do_read;
    logic              hit;

    assign opq_pop  = !opq_empty && (!head_op.is_read || !out_valid_reg || res_ready);
    assign do_write = opq_pop && !head_op.is_read;
    assign do_read  = opq_pop && head_op.is_read;
    assign hit      = !consumed_reg[rd_idx_reg];

    // Write events into the ring, read the entry under the read index
    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            ring_mem[wr_idx_reg] <= {head_op.code, head_op.kind};
        end
        if (do_read)
        begin
            data_reg <= ring_mem[rd_idx_reg];
            col_reg  <= head_op.col;
            row_reg  <= head_op.row;
        end
    end

    // Ring indexes, consumed flags and result handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            consumed_reg  <= '1;
            wr_idx_reg    <= '0;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
            avail_reg     <= 1'b0;
        end
        else
        begin
            if (do_write)
            begin
                consumed_reg[wr_idx_reg] <= 1'b0;
                wr_idx_reg <= (wr_idx_reg == LAST_IDX) ? '0 : wr_idx_reg + 1'b1;
            end
            if (do_read)
            begin
                avail_reg     <= hit;
                out_valid_reg <= 1'b1;
                if (hit)
                begin
                    consumed_reg[rd_idx_reg] <= 1'b1;
                    rd_idx_reg <= (rd_idx_reg == LAST_IDX) ? '0 : rd_idx_reg + 1'b1;
                end
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Zero kind and code when nothing was dequeued
    assign res_valid     = out_valid_reg;
    assign res_available = avail_reg;
    assign res_kind      = avail_reg ? data_reg[2:0]  : KIND_UNDEF;
    assign res_code      = avail_reg ? data_reg[10:3] : 8'd0;
    assign res_col       = col_reg;
    assign res_row       = row_reg;

endmodule

[hdl/terminal_key_event_decoder_queue_top.sv]
// Top level of the terminal key event decoder queue.
//
//  channel | dir | tdata fields (low bit up)                 | tuser
//  s_*     | in  | rx_byte[7:0]                              | cmd
//  m_*     | out | key_kind, key_code, mouse_col, mouse_row  | available
//  cfg_*   | in  | recording_enable (cfg_wdata)              | -
//
// One word per cycle sustained on the input while the op queue is not full;
// a dequeue result passes through the op queue, then the ring read into the
// output register. Reset clears parser and indexes and sets all consumed
// flags at once. A stalled output stops only dequeues at the head of the
// four-entry op queue; the input stalls when that queue is full.
module terminal_key_event_decoder_queue_top #(
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tuser,   // [0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [2:0] key_kind, [10:3] key_code,
                                   // [19:11] mouse_col, [28:20] mouse_row
    output logic        m_tuser,   // [0] available
    input  logic        cfg_we,
    input  logic        cfg_wdata
);
    import tkd_pkg::*;

    op_t               push_op;
    op_t               head_op;
    logic              op_push;
    logic              opq_full;
    logic              opq_empty;
    logic              opq_pop;
    logic [2:0]        res_kind;
    logic [7:0]        res_code;
    logic signed [8:0] res_col;
    logic signed [8:0] res_row;

    tkd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (s_tuser),
        .in_byte   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .opq_full  (opq_full),
        .op_push   (op_push),
        .op        (push_op)
    );

    tkd_opq u_opq (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (op_push),
        .push_op (push_op),
        .full    (opq_full),
        .pop     (opq_pop),
        .empty   (opq_empty),
        .head_op (head_op)
    );

    tkd_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .opq_empty     (opq_empty),
        .head_op       (head_op),
        .opq_pop       (opq_pop),
        .res_valid     (m_tvalid),
        .res_ready     (m_tready),
        .res_available (m_tuser),
        .res_kind      (res_kind),
        .res_code      (res_code),
        .res_col       (res_col),
        .res_row       (res_row)
    );

    // Pack the result word
    assign m_tdata = {3'b000, res_row, res_col, res_code, res_kind};

    // The parser never pushes into a full op queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        op_push |-> !opq_full)
        else $error("op queue overflow");

    // An empty dequeue reports zero kind and code
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata[10:0] == 11'd0))
        else $error("empty dequeue carries event data");

    // A new result only follows a dequeue op popped from the queue
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(opq_pop && head_op.is_read))
        else $error("result without dequeue op");

endmodule
